// ===== sv/ahpi_pkg.sv =====
// Shared widths, register indexes and reset values for the high-pass ingest block.
package ahpi_pkg;

    localparam int SAMPLE_W = 12;
    localparam int COEF_W   = 16;
    localparam int OUT_W    = 16;
    localparam int INDEX_W  = 16;
    localparam int STATE_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPTURE_ENABLE = 3'd0,
        CFG_DC_OFFSET      = 3'd1,
        CFG_INPUT_GAIN     = 3'd2,
        CFG_FEEDBACK       = 3'd3,
        CFG_FRAME_LENGTH   = 3'd4
    } t_cfg_idx;

    localparam logic [SAMPLE_W-1:0] DC_OFFSET_RST    = 12'd1024;
    localparam logic [COEF_W-1:0]   INPUT_GAIN_RST   = 16'd63059;
    localparam logic [COEF_W-1:0]   FEEDBACK_RST     = 16'd60581;
    localparam logic [INDEX_W-1:0]  FRAME_LENGTH_RST = 16'd1024;

endpackage

// ===== sv/audio_highpass_pingpong_ingest.sv =====
// First-order high-pass on converter samples with ping-pong frame indexing.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------------------------
//  sample   | i_adc_valid  | o_adc_stall  | i_adc_sample
//  result   | o_res_valid  | i_res_stall  | o_filtered_sample, o_clipped, o_bank,
//           |              |              | o_write_index, o_frame_ready
//  config   | i_cfg_we     | -            | i_cfg_index, i_cfg_data
//
//  One word per clock unless a stalled result backs up the input stage.
//  The gain product is formed in the input stage; the feedback multiply, saturation
//  and output scaling close the filter loop into the state and result registers.
//  Sync active-low reset clears state, bank, fill, valid flags; config gets defaults.
//  A stalled result holds; the input stage keeps taking words while it has room.
//  Words taken while capture is off are dropped.
module audio_highpass_pingpong_ingest (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adc_valid,
    output logic                                  o_adc_stall,
    input  logic [ahpi_pkg::SAMPLE_W-1:0]         i_adc_sample,
    output logic                                  o_res_valid,
    input  logic                                  i_res_stall,
    output logic signed [ahpi_pkg::OUT_W-1:0]     o_filtered_sample,
    output logic                                  o_clipped,
    output logic                                  o_bank,
    output logic [ahpi_pkg::INDEX_W-1:0]          o_write_index,
    output logic                                  o_frame_ready,
    input  logic                                  i_cfg_we,
    input  logic [ahpi_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ahpi_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import ahpi_pkg::*;

    localparam int X_W     = SAMPLE_W + 5;
    localparam int GPROD_W = COEF_W + 1 + X_W;
    localparam int GTERM_W = GPROD_W - 8;
    localparam int FPROD_W = COEF_W + 1 + STATE_W;
    localparam int FTERM_W = FPROD_W - 16;
    localparam int SUM_W   = STATE_W + 2;
    localparam int DIFF_W  = STATE_W + 1;
    localparam int Q_W     = DIFF_W - 8;

    logic                       r_capture_enable;
    logic [SAMPLE_W-1:0]        r_dc_offset;
    logic [COEF_W-1:0]          r_input_gain;
    logic [COEF_W-1:0]          r_feedback;
    logic [INDEX_W-1:0]         r_frame_length;

    logic signed [STATE_W-1:0]  r_mem;
    logic                       r_bank;
    logic [INDEX_W-1:0]         r_fill;

    logic                       r_a_valid;
    logic signed [GTERM_W-1:0]  r_a_gain;

    logic                       r_out_valid;
    logic signed [OUT_W-1:0]    r_out_sample;
    logic                       r_out_clipped;
    logic                       r_out_bank;
    logic [INDEX_W-1:0]         r_out_index;
    logic                       r_out_ready;

    logic                       w_out_room;
    logic                       w_a_room;
    logic                       w_take;
    logic                       w_move;

    logic signed [SAMPLE_W:0]   w_centered;
    logic signed [X_W-1:0]      w_x;
    logic signed [COEF_W:0]     w_gain_s;
    logic signed [GPROD_W-1:0]  w_gprod;

    logic signed [COEF_W:0]     w_fb_s;
    logic signed [FPROD_W-1:0]  w_fprod;
    logic signed [FTERM_W-1:0]  w_fterm;
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [STATE_W-1:0]  n_mem;
    logic signed [DIFF_W-1:0]   w_diff;
    logic signed [DIFF_W-1:0]   w_diff_adj;
    logic signed [Q_W-1:0]      w_q;
    logic signed [OUT_W-1:0]    n_out_sample;
    logic                       n_out_clipped;
    logic                       w_frame_end;
    logic [INDEX_W:0]           w_fill_inc;

    assign w_out_room  = !r_out_valid || !i_res_stall;
    assign w_a_room    = !r_a_valid || w_out_room;
    assign o_adc_stall = !w_a_room;
    assign w_take      = i_adc_valid && w_a_room;
    assign w_move      = r_a_valid && w_out_room;

    // input stage: center, scale by 16, apply gain
    assign w_centered = signed'({1'b0, i_adc_sample}) - signed'({1'b0, r_dc_offset});
    assign w_x        = signed'({w_centered, 4'b0000});
    assign w_gain_s   = signed'({1'b0, r_input_gain});
    assign w_gprod    = GPROD_W'(w_gain_s) * GPROD_W'(w_x);

    // loop stage: feedback, saturate state, form output
    assign w_fb_s  = signed'({1'b0, r_feedback});
    assign w_fprod = FPROD_W'(w_fb_s) * FPROD_W'(r_mem);
    assign w_fterm = w_fprod[FPROD_W-1:16];
    assign w_sum   = SUM_W'(r_a_gain) + SUM_W'(w_fterm);

    always_comb begin
        if (w_sum[SUM_W-1:STATE_W-1] == '0 || w_sum[SUM_W-1:STATE_W-1] == '1) begin
            n_mem = w_sum[STATE_W-1:0];
        end else if (w_sum[SUM_W-1]) begin
            n_mem = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            n_mem = {1'b0, {(STATE_W-1){1'b1}}};
        end
    end

    assign w_diff     = DIFF_W'(n_mem) - DIFF_W'(r_mem);
    assign w_diff_adj = w_diff[DIFF_W-1] ? w_diff + DIFF_W'(255) : w_diff;
    assign w_q        = w_diff_adj[DIFF_W-1:8];

    always_comb begin
        if (w_q[Q_W-1:OUT_W-1] == '0 || w_q[Q_W-1:OUT_W-1] == '1) begin
            n_out_sample  = w_q[OUT_W-1:0];
            n_out_clipped = 1'b0;
        end else if (w_q[Q_W-1]) begin
            n_out_sample  = {1'b1, {(OUT_W-1){1'b0}}};
            n_out_clipped = 1'b1;
        end else begin
            n_out_sample  = {1'b0, {(OUT_W-1){1'b1}}};
            n_out_clipped = 1'b1;
        end
    end

    assign w_fill_inc  = {1'b0, r_fill} + (INDEX_W+1)'(1);
    assign w_frame_end = w_fill_inc >= {1'b0, r_frame_length};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture_enable <= 1'b0;
            r_dc_offset      <= DC_OFFSET_RST;
            r_input_gain     <= INPUT_GAIN_RST;
            r_feedback       <= FEEDBACK_RST;
            r_frame_length   <= FRAME_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CAPTURE_ENABLE: r_capture_enable <= i_cfg_data[0];
                CFG_DC_OFFSET:      r_dc_offset      <= i_cfg_data[SAMPLE_W-1:0];
                CFG_INPUT_GAIN:     r_input_gain     <= i_cfg_data[COEF_W-1:0];
                CFG_FEEDBACK:       r_feedback       <= i_cfg_data[COEF_W-1:0];
                CFG_FRAME_LENGTH:   r_frame_length   <= i_cfg_data[INDEX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_room) begin
            r_a_valid <= w_take && r_capture_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_a_gain <= w_gprod[GPROD_W-1:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem  <= '0;
            r_bank <= 1'b0;
            r_fill <= '0;
        end else if (w_move) begin
            r_mem <= n_mem;
            if (w_frame_end) begin
                r_bank <= !r_bank;
                r_fill <= '0;
            end else begin
                r_fill <= w_fill_inc[INDEX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_room) begin
            r_out_valid <= w_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_sample  <= n_out_sample;
            r_out_clipped <= n_out_clipped;
            r_out_bank    <= r_bank;
            r_out_index   <= r_fill;
            r_out_ready   <= w_frame_end;
        end
    end

    assign o_res_valid       = r_out_valid;
    assign o_filtered_sample = r_out_sample;
    assign o_clipped         = r_out_clipped;
    assign o_bank            = r_out_bank;
    assign o_write_index     = r_out_index;
    assign o_frame_ready     = r_out_ready;

endmodule
